@@ hw/rtl/wrcs_pkg.sv @@
// Package for the weighted rank candidate selector.
// Holds the sequencer state type, the cell control bundle, register indexes and reset weights.
// No dependencies.
package wrcs_pkg;

    localparam int NUM_METRICS = 4;
    localparam int COST_W      = 16;
    localparam int WEIGHT_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int INDEX_W     = 4;
    localparam int SCORE_W     = 14;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CRUISE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_OBSTACLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LANE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SPEED    = 2'd3;

    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CRUISE   = 8'd0;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_OBSTACLE = 8'd60;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_LANE     = 8'd19;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_SPEED    = 8'd21;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RANK,
        ST_SUM,
        ST_SCAN,
        ST_DONE
    } t_state;

    // control bundle broadcast from the sequencer to every cell
    typedef struct packed {
        logic       load;   // capture the incoming word into the cell at the load pointer
        logic       prep;   // seed travelling copies, ranks and accumulators
        logic       rank;   // compare against the travelling copy, then rotate the ring
        logic       acc;    // accumulate weight * rank for metric sel
        logic       scan;   // pass the running best one cell along the chain
        logic [1:0] sel;    // metric under accumulation
    } t_cell_ctl;

endpackage

@@ hw/rtl/wrcs_cell.sv @@
// One candidate cell: stored costs, per-metric rank counters, weighted sum and best-so-far stage.
// Uses wrcs_pkg. Neighbours are joined into a ring for ranking and a chain for the minimum scan.
module wrcs_cell #(
    parameter int MAX_CANDIDATES = 16,
    parameter int METRIC_WIDTH   = 16,
    parameter int CELL_INDEX     = 0
) (
    input  logic                                                i_clk,
    input  wrcs_pkg::t_cell_ctl                                 i_ctl,
    input  logic [$clog2(MAX_CANDIDATES+1)-1:0]                 i_count,
    input  logic [wrcs_pkg::NUM_METRICS-1:0][METRIC_WIDTH-1:0]  i_metrics,
    input  logic [wrcs_pkg::WEIGHT_W-1:0]                       i_weight,
    input  logic [wrcs_pkg::NUM_METRICS-1:0][METRIC_WIDTH-1:0]  i_trav_metrics,
    input  logic [$clog2(MAX_CANDIDATES)-1:0]                   i_trav_idx,
    input  logic                                                i_trav_valid,
    output logic [wrcs_pkg::NUM_METRICS-1:0][METRIC_WIDTH-1:0]  o_trav_metrics,
    output logic [$clog2(MAX_CANDIDATES)-1:0]                   o_trav_idx,
    output logic                                                o_trav_valid,
    input  logic                                                i_best_valid,
    input  logic [$clog2(MAX_CANDIDATES)-1:0]                   i_best_idx,
    input  logic [wrcs_pkg::WEIGHT_W+$clog2(MAX_CANDIDATES+1)+1:0] i_best_sum,
    output logic                                                o_best_valid,
    output logic [$clog2(MAX_CANDIDATES)-1:0]                   o_best_idx,
    output logic [wrcs_pkg::WEIGHT_W+$clog2(MAX_CANDIDATES+1)+1:0] o_best_sum
);

    localparam int NM     = wrcs_pkg::NUM_METRICS;
    localparam int CNT_W  = $clog2(MAX_CANDIDATES + 1);
    localparam int IDX_W  = $clog2(MAX_CANDIDATES);
    localparam int RANK_W = CNT_W;
    localparam int PROD_W = wrcs_pkg::WEIGHT_W + RANK_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);

    logic [NM-1:0][METRIC_WIDTH-1:0] r_metrics;
    logic [NM-1:0][METRIC_WIDTH-1:0] r_trav_metrics;
    logic [IDX_W-1:0]                r_trav_idx;
    logic                            r_trav_valid;
    logic [NM-1:0][RANK_W-1:0]       r_rank;
    logic [SUM_W-1:0]                r_sum;
    logic                            r_best_valid;
    logic [IDX_W-1:0]                r_best_idx;
    logic [SUM_W-1:0]                r_best_sum;

    logic [NM-1:0]   beats;
    logic            own_valid;
    logic [PROD_W-1:0] prod;
    logic            take_own;

    assign own_valid = (MY_CNT < i_count);

    always_comb begin
        for (int m = 0; m < NM; m++) begin
            beats[m] = r_trav_valid &&
                       ((r_trav_metrics[m] < r_metrics[m]) ||
                        ((r_trav_metrics[m] == r_metrics[m]) && (r_trav_idx < MY_IDX)));
        end
    end

    assign prod     = PROD_W'(i_weight) * PROD_W'(r_rank[i_ctl.sel]);
    // strict compare keeps the lower index on a tie
    assign take_own = own_valid && (!i_best_valid || (r_sum < i_best_sum));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_count == MY_CNT)) begin
            r_metrics <= i_metrics;
        end
        if (i_ctl.prep) begin
            r_trav_metrics <= r_metrics;
            r_trav_idx     <= MY_IDX;
            r_trav_valid   <= own_valid;
            r_sum          <= '0;
            for (int m = 0; m < NM; m++) begin
                r_rank[m] <= RANK_W'(1);
            end
        end else if (i_ctl.rank) begin
            r_trav_metrics <= i_trav_metrics;
            r_trav_idx     <= i_trav_idx;
            r_trav_valid   <= i_trav_valid;
            for (int m = 0; m < NM; m++) begin
                if (beats[m]) begin
                    r_rank[m] <= r_rank[m] + RANK_W'(1);
                end
            end
        end
        if (i_ctl.acc) begin
            r_sum <= r_sum + SUM_W'(prod);
        end
        if (i_ctl.scan) begin
            r_best_valid <= i_best_valid || own_valid;
            r_best_idx   <= take_own ? MY_IDX : i_best_idx;
            r_best_sum   <= take_own ? r_sum  : i_best_sum;
        end
    end

    assign o_trav_metrics = r_trav_metrics;
    assign o_trav_idx     = r_trav_idx;
    assign o_trav_valid   = r_trav_valid;
    assign o_best_valid   = r_best_valid;
    assign o_best_idx     = r_best_idx;
    assign o_best_sum     = r_best_sum;

endmodule

@@ hw/rtl/wrcs_ctrl.sv @@
// Sequencer: load pointer, phase state machine and step counter for the cell row.
// Uses wrcs_pkg.
module wrcs_ctrl #(
    parameter int MAX_CANDIDATES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_last,
    output logic                                o_busy,
    output logic                                o_done,
    output wrcs_pkg::t_cell_ctl                 o_ctl,
    output logic [$clog2(MAX_CANDIDATES+1)-1:0] o_count
);

    localparam int CNT_W  = $clog2(MAX_CANDIDATES + 1);
    localparam int STEP_W = ($clog2(MAX_CANDIDATES) > 2) ? $clog2(MAX_CANDIDATES) : 2;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_CANDIDATES - 1);
    localparam logic [STEP_W-1:0] SUM_LAST  = STEP_W'(wrcs_pkg::NUM_METRICS - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_CANDIDATES);

    wrcs_pkg::t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              accept;
    logic              load;

    assign accept = i_start && (r_state == wrcs_pkg::ST_IDLE);
    assign load   = accept && (r_count != CNT_FULL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wrcs_pkg::ST_IDLE: begin
                if (accept && i_last) n_state = wrcs_pkg::ST_PREP;
            end
            wrcs_pkg::ST_PREP: n_state = wrcs_pkg::ST_RANK;
            wrcs_pkg::ST_RANK: begin
                if (r_step == STEP_LAST) n_state = wrcs_pkg::ST_SUM;
            end
            wrcs_pkg::ST_SUM: begin
                if (r_step == SUM_LAST) n_state = wrcs_pkg::ST_SCAN;
            end
            wrcs_pkg::ST_SCAN: begin
                if (r_step == STEP_LAST) n_state = wrcs_pkg::ST_DONE;
            end
            wrcs_pkg::ST_DONE: n_state = wrcs_pkg::ST_IDLE;
            default:           n_state = wrcs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_step  = (n_state != r_state) ? '0 : r_step + STEP_W'(1);
        n_count = r_count;
        if (r_state == wrcs_pkg::ST_DONE) begin
            n_count = '0;
        end else if (load) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_comb begin
        o_ctl      = '0;
        o_ctl.load = load;
        o_ctl.sel  = r_step[1:0];
        o_busy     = 1'b1;
        o_done     = 1'b0;
        unique case (r_state)
            wrcs_pkg::ST_IDLE: o_busy     = 1'b0;
            wrcs_pkg::ST_PREP: o_ctl.prep = 1'b1;
            wrcs_pkg::ST_RANK: o_ctl.rank = 1'b1;
            wrcs_pkg::ST_SUM:  o_ctl.acc  = 1'b1;
            wrcs_pkg::ST_SCAN: o_ctl.scan = 1'b1;
            wrcs_pkg::ST_DONE: o_done     = 1'b1;
            default:           o_busy     = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrcs_pkg::ST_IDLE;
            r_step  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

@@ hw/rtl/weighted_rank_candidate_selector.sv @@
// Top level of the weighted rank candidate selector: weight registers, sequencer, cell row.
// Uses wrcs_pkg, wrcs_ctrl and wrcs_cell.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  input    | start & !busy          | i_cost_cruise/obstacle/lane/speed, i_last_candidate
//  result   | o_done (one cycle)     | o_best_index, o_best_score
//  config   | i_cfg_we               | i_cfg_index, i_cfg_data
//
// Candidate words are loaded as start is accepted and may follow back to back while busy is low.
// After the word marked last the cell row runs the seed step, ring rotation for ranking,
// four multiply-accumulate steps and the chain scan for the minimum, then o_done pulses
// for one cycle; busy stays high until that cycle ends.
// Reset is synchronous, active low, and clears the sequencer and the weights; the
// candidate store is not cleared. Results cannot be stalled.
module weighted_rank_candidate_selector #(
    parameter int MAX_CANDIDATES = 16,
    parameter int METRIC_WIDTH   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [wrcs_pkg::COST_W-1:0]        i_cost_cruise,
    input  logic [wrcs_pkg::COST_W-1:0]        i_cost_obstacle,
    input  logic [wrcs_pkg::COST_W-1:0]        i_cost_lane,
    input  logic [wrcs_pkg::COST_W-1:0]        i_cost_speed,
    input  logic                               i_last_candidate,
    output logic                               o_done,
    output logic [wrcs_pkg::INDEX_W-1:0]       o_best_index,
    output logic [wrcs_pkg::SCORE_W-1:0]       o_best_score,
    input  logic                               i_cfg_we,
    input  logic [wrcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wrcs_pkg::WEIGHT_W-1:0]      i_cfg_data
);

    localparam int NM    = wrcs_pkg::NUM_METRICS;
    localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
    localparam int IDX_W = $clog2(MAX_CANDIDATES);
    localparam int SUM_W = wrcs_pkg::WEIGHT_W + CNT_W + 2;

    logic [NM-1:0][wrcs_pkg::WEIGHT_W-1:0] r_weight;
    wrcs_pkg::t_cell_ctl                   ctl;
    logic [CNT_W-1:0]                      count;
    logic [NM-1:0][METRIC_WIDTH-1:0]       load_metrics;
    logic [wrcs_pkg::WEIGHT_W-1:0]         weight_sel;

    logic [MAX_CANDIDATES-1:0][NM-1:0][METRIC_WIDTH-1:0] trav_metrics;
    logic [MAX_CANDIDATES-1:0][IDX_W-1:0]                trav_idx;
    logic [MAX_CANDIDATES-1:0]                           trav_valid;
    logic [MAX_CANDIDATES:0]                             best_valid;
    logic [MAX_CANDIDATES:0][IDX_W-1:0]                  best_idx;
    logic [MAX_CANDIDATES:0][SUM_W-1:0]                  best_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight[wrcs_pkg::REG_WEIGHT_CRUISE]   <= wrcs_pkg::RST_WEIGHT_CRUISE;
            r_weight[wrcs_pkg::REG_WEIGHT_OBSTACLE] <= wrcs_pkg::RST_WEIGHT_OBSTACLE;
            r_weight[wrcs_pkg::REG_WEIGHT_LANE]     <= wrcs_pkg::RST_WEIGHT_LANE;
            r_weight[wrcs_pkg::REG_WEIGHT_SPEED]    <= wrcs_pkg::RST_WEIGHT_SPEED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wrcs_pkg::REG_WEIGHT_CRUISE:   r_weight[wrcs_pkg::REG_WEIGHT_CRUISE]   <= i_cfg_data;
                wrcs_pkg::REG_WEIGHT_OBSTACLE: r_weight[wrcs_pkg::REG_WEIGHT_OBSTACLE] <= i_cfg_data;
                wrcs_pkg::REG_WEIGHT_LANE:     r_weight[wrcs_pkg::REG_WEIGHT_LANE]     <= i_cfg_data;
                wrcs_pkg::REG_WEIGHT_SPEED:    r_weight[wrcs_pkg::REG_WEIGHT_SPEED]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign weight_sel = r_weight[ctl.sel];

    // costs are kept to METRIC_WIDTH bits
    assign load_metrics[0] = METRIC_WIDTH'(i_cost_cruise);
    assign load_metrics[1] = METRIC_WIDTH'(i_cost_obstacle);
    assign load_metrics[2] = METRIC_WIDTH'(i_cost_lane);
    assign load_metrics[3] = METRIC_WIDTH'(i_cost_speed);

    wrcs_ctrl #(
        .MAX_CANDIDATES(MAX_CANDIDATES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_last_candidate),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_ctl   (ctl),
        .o_count (count)
    );

    // head of the scan chain carries no candidate
    assign best_valid[0] = 1'b0;
    assign best_idx[0]   = '0;
    assign best_sum[0]   = '0;

    for (genvar k = 0; k < MAX_CANDIDATES; k++) begin : g_cell
        localparam int PREV = (k == 0) ? MAX_CANDIDATES - 1 : k - 1;
        wrcs_cell #(
            .MAX_CANDIDATES (MAX_CANDIDATES),
            .METRIC_WIDTH   (METRIC_WIDTH),
            .CELL_INDEX     (k)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (ctl),
            .i_count        (count),
            .i_metrics      (load_metrics),
            .i_weight       (weight_sel),
            .i_trav_metrics (trav_metrics[PREV]),
            .i_trav_idx     (trav_idx[PREV]),
            .i_trav_valid   (trav_valid[PREV]),
            .o_trav_metrics (trav_metrics[k]),
            .o_trav_idx     (trav_idx[k]),
            .o_trav_valid   (trav_valid[k]),
            .i_best_valid   (best_valid[k]),
            .i_best_idx     (best_idx[k]),
            .i_best_sum     (best_sum[k]),
            .o_best_valid   (best_valid[k+1]),
            .o_best_idx     (best_idx[k+1]),
            .o_best_sum     (best_sum[k+1])
        );
    end

    assign o_best_index = wrcs_pkg::INDEX_W'(best_idx[MAX_CANDIDATES]);
    assign o_best_score = wrcs_pkg::SCORE_W'(best_sum[MAX_CANDIDATES]);

endmodule
